/* rtl/core/ltkc_pkg.sv */
// shared types, constants and control-store program for the key cache
`default_nettype none

package ltkc_pkg;

    // field widths
    localparam int KEY_W     = 32;
    localparam int HANDLE_W  = 32;
    localparam int TICK_W    = 32;
    localparam int CMD_W     = 2;
    localparam int CAP_W     = 11;
    localparam int COUNT_W   = 11;
    localparam int TOTAL_W   = 32;
    localparam int IN_DATA_W = 96;
    localparam int OUT_PAD_W = 3;
    localparam int OUT_DATA_W = 144;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1000;

    // operation codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // one stored entry: key in the low bits, then handle, then stamp
    typedef struct packed {
        logic [TICK_W-1:0]   stamp;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // input beat payload, first field in the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0]   now_tick;
        logic [HANDLE_W-1:0] value_handle;
        logic [KEY_W-1:0]    lookup_key;
    } in_item_t;

    // result beat payload, first field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [TOTAL_W-1:0]   miss_total;
        logic [TOTAL_W-1:0]   hit_total;
        logic [COUNT_W-1:0]   entry_count;
        logic [HANDLE_W-1:0]  released_handle;
        logic                 released_valid;
        logic [HANDLE_W-1:0]  data_out;
        logic                 found;
    } out_item_t;

    // datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_COMMIT,
        OP_MOVE,
        OP_CLEAR,
        OP_EMIT
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_IS_CLEAR,
        JC_PUT_ZERO,
        JC_SCAN_MORE,
        JC_NO_MOVE,
        JC_OUT_BUSY
    } jcond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // program addresses
    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_DISPATCH = 3'd1;
    localparam step_t STEP_PUTCHK   = 3'd2;
    localparam step_t STEP_SCAN     = 3'd3;
    localparam step_t STEP_COMMIT   = 3'd4;
    localparam step_t STEP_MOVE     = 3'd5;
    localparam step_t STEP_CLEAR    = 3'd6;
    localparam step_t STEP_FINISH   = 3'd7;

    typedef struct packed {
        uop_t   op;
        jcond_t cond;
        step_t  target;
    } uword_t;

    // datapath status that the sequencer branches on
    typedef struct packed {
        logic no_input;
        logic is_clear;
        logic put_zero;
        logic scan_more;
        logic no_move;
        logic out_busy;
    } seq_status_t;

    // control store; the finish step falls through to idle by counter wrap
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            STEP_IDLE:     w = '{op: OP_LOAD,   cond: JC_NO_INPUT,  target: STEP_IDLE};
            STEP_DISPATCH: w = '{op: OP_NONE,   cond: JC_IS_CLEAR,  target: STEP_CLEAR};
            STEP_PUTCHK:   w = '{op: OP_NONE,   cond: JC_PUT_ZERO,  target: STEP_FINISH};
            STEP_SCAN:     w = '{op: OP_SCAN,   cond: JC_SCAN_MORE, target: STEP_SCAN};
            STEP_COMMIT:   w = '{op: OP_COMMIT, cond: JC_NO_MOVE,   target: STEP_FINISH};
            STEP_MOVE:     w = '{op: OP_MOVE,   cond: JC_ALWAYS,    target: STEP_FINISH};
            STEP_CLEAR:    w = '{op: OP_CLEAR,  cond: JC_NEVER,     target: STEP_FINISH};
            STEP_FINISH:   w = '{op: OP_EMIT,   cond: JC_OUT_BUSY,  target: STEP_FINISH};
            default:       w = '{op: OP_NONE,   cond: JC_NEVER,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ltkc_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module ltkc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/ltkc_seq.sv */
// microcode sequencer: step counter, control store and jump logic
`default_nettype none

module ltkc_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ltkc_pkg::seq_status_t status,
    output ltkc_pkg::uword_t          ctl
);

    ltkc_pkg::step_t step_reg;
    ltkc_pkg::step_t step_next;
    logic            take;

    // fetch the control word of the current step
    always_comb begin
        ctl = ltkc_pkg::ucode_rom(step_reg);
    end

    // evaluate the jump condition
    always_comb begin
        unique case (ctl.cond)
            ltkc_pkg::JC_NEVER:     take = 1'b0;
            ltkc_pkg::JC_ALWAYS:    take = 1'b1;
            ltkc_pkg::JC_NO_INPUT:  take = status.no_input;
            ltkc_pkg::JC_IS_CLEAR:  take = status.is_clear;
            ltkc_pkg::JC_PUT_ZERO:  take = status.put_zero;
            ltkc_pkg::JC_SCAN_MORE: take = status.scan_more;
            ltkc_pkg::JC_NO_MOVE:   take = status.no_move;
            ltkc_pkg::JC_OUT_BUSY:  take = status.out_busy;
            default:                take = 1'b0;
        endcase
    end

    // next step: jump target or fall through (last step wraps to idle)
    always_comb begin
        step_next = take ? ctl.target : (step_reg + ltkc_pkg::step_t'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ltkc_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lru_timestamp_key_cache.sv */
// fully associative key cache with timestamp lru replacement
// Usage:
//   s_ channel: one beat per operation. s_tuser carries the command (get, put,
//   remove, clear), s_tdata the key, handle and current tick.
//   m_ channel: exactly one result beat per operation, in order.
//   cfg_ channel: writes capacity_in_use (ready out of reset; write only while idle).
// Sequence:
//   A small microcode sequencer walks each get, put or remove through a linear
//   scan of the entry ram, one entry per cycle through the registered ram read
//   port. The steps are load, dispatch, put check, scan (ended early by a key
//   match), commit and the result step, which loads the output register; a remove
//   that moves an entry adds a move step before the result step. Clear goes from
//   dispatch to a clear step, and put of handle zero from put check straight to
//   the result step.
//   The next beat is taken in the cycle after a result is loaded into the output
//   register, so one result can wait while the next operation runs.
// Reset: fill count, hit and miss totals go to zero and capacity to 1000; the
//   entry ram is not cleared since only the data of filled entries is ever used.
// Stall: when m_tready is low the finished result holds in the output
//   register and the following operation waits at its result step.
`default_nettype none

module lru_timestamp_key_cache #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input beats
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ltkc_pkg::IN_DATA_W-1:0]   s_tdata,  // lookup_key, value_handle, now_tick
    input  wire logic [ltkc_pkg::CMD_W-1:0]       s_tuser,  // cmd
    // result beats
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [ltkc_pkg::OUT_DATA_W-1:0]  m_tdata,  // found, data_out, released_valid,
                                                            // released_handle, entry_count,
                                                            // hit_total, miss_total, zero pad
    // capacity register write
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ltkc_pkg::CAP_W-1:0]       cfg_data
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > ltkc_pkg::CAP_W) ? CW : ltkc_pkg::CAP_W;

    // sequencer interface
    ltkc_pkg::uword_t      ctl;
    ltkc_pkg::seq_status_t status;

    // control state
    logic [CW-1:0]                    fill_reg, fill_next;
    logic [ltkc_pkg::TOTAL_W-1:0]     hits_reg, hits_next;
    logic [ltkc_pkg::TOTAL_W-1:0]     misses_reg, misses_next;
    logic [ltkc_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic                             pend_reg, pend_next;
    logic                             match_reg, match_next;

    // payload state
    ltkc_pkg::cmd_t                   cmd_reg, cmd_next;
    ltkc_pkg::in_item_t               item_reg, item_next;
    logic [CW-1:0]                    rd_addr_reg, rd_addr_next;
    logic [AW-1:0]                    pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                    match_idx_reg, match_idx_next;
    logic [ltkc_pkg::HANDLE_W-1:0]    match_handle_reg, match_handle_next;
    logic [AW-1:0]                    victim_idx_reg, victim_idx_next;
    logic [ltkc_pkg::HANDLE_W-1:0]    victim_handle_reg, victim_handle_next;
    logic [ltkc_pkg::TICK_W-1:0]      oldest_reg, oldest_next;
    logic                             found_reg, found_next;
    logic [ltkc_pkg::HANDLE_W-1:0]    data_reg, data_next;
    logic                             rel_valid_reg, rel_valid_next;
    logic [ltkc_pkg::HANDLE_W-1:0]    rel_handle_reg, rel_handle_next;
    ltkc_pkg::out_item_t              m_tdata_reg, m_tdata_next;

    // ram ports
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    ltkc_pkg::entry_t                 ram_wdata;
    logic [AW-1:0]                    ram_raddr;
    logic [ltkc_pkg::ENTRY_W-1:0]     ram_q_raw;
    ltkc_pkg::entry_t                 ram_q;

    // datapath helpers
    logic                             issue;
    logic                             key_hit;
    logic                             full;
    logic                             out_busy;
    logic                             in_accept;
    logic [CW-1:0]                    fill_dec;

    ltkc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctl     (ctl)
    );

    ltkc_ram #(
        .WIDTH (ltkc_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_q_raw)
    );

    assign ram_q = ltkc_pkg::entry_t'(ram_q_raw);

    // handshakes
    assign s_tready  = aresetn && (ctl.op == ltkc_pkg::OP_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // scan compare on the entry returned by the ram
    assign fill_dec = fill_reg - CW'(1);
    assign issue    = (rd_addr_reg < fill_reg);
    assign key_hit  = pend_reg && (ram_q.key == item_reg.lookup_key)
                      && ((cmd_reg != ltkc_pkg::CMD_GET) || (ram_q.handle != '0));

    // full test; capacity zero acts as one, above the array size as the size
    always_comb begin
        if (cap_reg == '0) begin
            full = (fill_reg != '0);
        end else begin
            full = (CMPW'(fill_reg) >= CMPW'(cap_reg)) || (fill_reg == CW'(MAX_ENTRIES));
        end
    end

    // ram read address: scan pointer, or the last entry during commit
    assign ram_raddr = (ctl.op == ltkc_pkg::OP_COMMIT) ? fill_dec[AW-1:0]
                                                       : rd_addr_reg[AW-1:0];

    // branch status for the sequencer
    always_comb begin
        status.no_input  = !s_tvalid;
        status.is_clear  = (cmd_reg == ltkc_pkg::CMD_CLEAR);
        status.put_zero  = (cmd_reg == ltkc_pkg::CMD_PUT) && (item_reg.value_handle == '0);
        status.scan_more = !key_hit && (issue || pend_reg);
        status.no_move   = !((cmd_reg == ltkc_pkg::CMD_REMOVE) && match_reg
                             && (CW'(match_idx_reg) < fill_dec));
        status.out_busy  = out_busy;
    end

    // datapath next-state logic driven by the control word
    always_comb begin
        fill_next          = fill_reg;
        hits_next          = hits_reg;
        misses_next        = misses_reg;
        cap_next           = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
        m_tvalid_next      = m_tready ? 1'b0 : m_tvalid_reg;
        pend_next          = pend_reg;
        match_next         = match_reg;
        cmd_next           = cmd_reg;
        item_next          = item_reg;
        rd_addr_next       = rd_addr_reg;
        pend_idx_next      = pend_idx_reg;
        match_idx_next     = match_idx_reg;
        match_handle_next  = match_handle_reg;
        victim_idx_next    = victim_idx_reg;
        victim_handle_next = victim_handle_reg;
        oldest_next        = oldest_reg;
        found_next         = found_reg;
        data_next          = data_reg;
        rel_valid_next     = rel_valid_reg;
        rel_handle_next    = rel_handle_reg;
        m_tdata_next       = m_tdata_reg;
        ram_we             = 1'b0;
        ram_waddr          = match_idx_reg;
        ram_wdata          = '{stamp: item_reg.now_tick, handle: item_reg.value_handle,
                               key: item_reg.lookup_key};

        unique case (ctl.op)
            ltkc_pkg::OP_NONE: begin
            end

            // take a new operation and reset the scan state
            ltkc_pkg::OP_LOAD: begin
                if (in_accept) begin
                    cmd_next        = ltkc_pkg::cmd_t'(s_tuser);
                    item_next       = ltkc_pkg::in_item_t'(s_tdata);
                    rd_addr_next    = '0;
                    pend_next       = 1'b0;
                    match_next      = 1'b0;
                    found_next      = 1'b0;
                    data_next       = '0;
                    rel_valid_next  = 1'b0;
                    rel_handle_next = '0;
                end
            end

            // one entry per cycle: issue a read, compare the previous one
            ltkc_pkg::OP_SCAN: begin
                pend_next     = issue;
                pend_idx_next = rd_addr_reg[AW-1:0];
                if (issue) begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (key_hit) begin
                    match_next        = 1'b1;
                    match_idx_next    = pend_idx_reg;
                    match_handle_next = ram_q.handle;
                end
                if (pend_reg && ((pend_idx_reg == '0) || (ram_q.stamp < oldest_reg))) begin
                    oldest_next        = ram_q.stamp;
                    victim_idx_next    = pend_idx_reg;
                    victim_handle_next = ram_q.handle;
                end
            end

            // apply the operation to the matched, victim or appended entry
            ltkc_pkg::OP_COMMIT: begin
                case (cmd_reg)
                    ltkc_pkg::CMD_GET: begin
                        if (match_reg) begin
                            ram_we           = 1'b1;
                            ram_wdata.handle = match_handle_reg;
                            hits_next        = hits_reg + ltkc_pkg::TOTAL_W'(1);
                            found_next       = 1'b1;
                            data_next        = match_handle_reg;
                        end else begin
                            misses_next = misses_reg + ltkc_pkg::TOTAL_W'(1);
                        end
                    end
                    ltkc_pkg::CMD_PUT: begin
                        if (match_reg) begin
                            ram_we = 1'b1;
                        end else if (full) begin
                            ram_we          = 1'b1;
                            ram_waddr       = victim_idx_reg;
                            rel_valid_next  = 1'b1;
                            rel_handle_next = victim_handle_reg;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = fill_reg[AW-1:0];
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    ltkc_pkg::CMD_REMOVE: begin
                        if (match_reg) begin
                            found_next      = 1'b1;
                            rel_valid_next  = 1'b1;
                            rel_handle_next = match_handle_reg;
                            fill_next       = fill_dec;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // move the last entry into the removed slot
            ltkc_pkg::OP_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_q;
            end

            ltkc_pkg::OP_CLEAR: begin
                fill_next = '0;
            end

            // load the result beat once the output register is free
            ltkc_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_tvalid_next                = 1'b1;
                    m_tdata_next.pad             = '0;
                    m_tdata_next.miss_total      = misses_reg;
                    m_tdata_next.hit_total       = hits_reg;
                    m_tdata_next.entry_count     = ltkc_pkg::COUNT_W'(fill_reg);
                    m_tdata_next.released_handle = rel_handle_reg;
                    m_tdata_next.released_valid  = rel_valid_reg;
                    m_tdata_next.data_out        = data_reg;
                    m_tdata_next.found           = found_reg;
                end
            end

            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            cap_reg      <= ltkc_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            match_reg    <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
            match_reg    <= match_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg           <= cmd_next;
        item_reg          <= item_next;
        rd_addr_reg       <= rd_addr_next;
        pend_idx_reg      <= pend_idx_next;
        match_idx_reg     <= match_idx_next;
        match_handle_reg  <= match_handle_next;
        victim_idx_reg    <= victim_idx_next;
        victim_handle_reg <= victim_handle_next;
        oldest_reg        <= oldest_next;
        found_reg         <= found_next;
        data_reg          <= data_next;
        rel_valid_reg     <= rel_valid_next;
        rel_handle_reg    <= rel_handle_next;
        m_tdata_reg       <= m_tdata_next;
    end

endmodule

`default_nettype wire
